@@ hw/rtl/ubdc_pkg.sv @@
// Shared types, constants and prescaler decode for the baud divisor calculator.
`default_nettype none

package ubdc_pkg;

   // Register indexes on the configuration port
   localparam logic CSR_INTERNAL_CLOCK = 1'b0;
   localparam logic CSR_EXTERNAL_CLOCK = 1'b1;

   // Field widths
   localparam int CLK_W   = 27;
   localparam int CFG_W   = 16;
   localparam int BAUD_W  = 24;
   localparam int WORD_W  = 16;
   localparam int SHIFT_W = 4;

   // Oscillator values after reset
   localparam logic [CLK_W-1:0] INTERNAL_CLOCK_RESET = 27'd16000000;
   localparam logic [CLK_W-1:0] EXTERNAL_CLOCK_RESET = 27'd8000000;

   // Divider cells: quotient bits and remainder width
   localparam int QUO_W = 32;
   localparam int REM_W = 26;
   localparam int STEPS = QUO_W;

   // Split of usartdiv by 100: ceil(2^37 / 100), exact for any 32-bit value
   localparam logic [15:0] DIV100_MUL_LO = 16'h851F;
   localparam logic [15:0] DIV100_MUL_HI = 16'h51EB;
   localparam int          DIV100_SHIFT  = 37;
   localparam int          QMANT_W       = 2*QUO_W - DIV100_SHIFT;

   // Rounding of the fraction
   localparam logic [10:0]      ROUND_HALF  = 11'd50;
   localparam logic [10:0]      RECIP_100   = 11'd1311;   // 2^17 / 100, rounded up
   localparam int               RECIP_SHIFT = 17;
   localparam int               MANT_W      = 12;

   // One item travelling down a divider chain. nq holds the dividend bits not
   // yet consumed in its top and the quotient bits produced so far at the bottom.
   typedef struct packed {
      logic             valid;
      logic             over8;
      logic             zero_baud;
      logic [QUO_W-1:0] nq;
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] den;
   } cell_type;

   // AHB prescale code to right-shift amount
   function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [3:0] code);
      logic [SHIFT_W-1:0] sh;
      if (!code[3]) begin
         sh = 4'd0;
      end else begin
         unique case (code[2:0])
            3'd0: sh = 4'd1;
            3'd1: sh = 4'd2;
            3'd2: sh = 4'd3;
            3'd3: sh = 4'd4;
            3'd4: sh = 4'd6;
            3'd5: sh = 4'd7;
            3'd6: sh = 4'd8;
            3'd7: sh = 4'd9;
            default: sh = 4'd0;
         endcase
      end
      return sh;
   endfunction

   // APB2 prescale code to right-shift amount
   function automatic logic [SHIFT_W-1:0] apb_shift(input logic [2:0] code);
      logic [SHIFT_W-1:0] sh;
      sh = code[2] ? {2'b00, code[1:0]} + 4'd1 : 4'd0;
      return sh;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ubdc_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per item and registers it.
`default_nettype none

module ubdc_div_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire ubdc_pkg::cell_type cell_in,
   output ubdc_pkg::cell_type      cell_out
);

   logic [ubdc_pkg::REM_W:0] trial;
   logic [ubdc_pkg::REM_W:0] diff;
   logic                     take;
   ubdc_pkg::cell_type       cell_in_next;
   ubdc_pkg::cell_type       cell_ff;

   // Shift in the next dividend bit, subtract the divisor when it fits
   always_comb begin
      trial = {cell_in.rem, cell_in.nq[ubdc_pkg::QUO_W-1]};
      take  = (trial >= {1'b0, cell_in.den});
      diff  = trial - {1'b0, cell_in.den};
      cell_in_next     = cell_in;
      cell_in_next.rem = take ? diff[ubdc_pkg::REM_W-1:0] : trial[ubdc_pkg::REM_W-1:0];
      cell_in_next.nq  = {cell_in.nq[ubdc_pkg::QUO_W-2:0], take};
   end

   // Advance the item when the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ubdc_div_chain.sv @@
// Row of STEPS division cells giving a full quotient and remainder.
`default_nettype none

module ubdc_div_chain (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire ubdc_pkg::cell_type chain_in,
   output ubdc_pkg::cell_type      chain_out
);

   ubdc_pkg::cell_type links [0:ubdc_pkg::STEPS];

   assign links[0] = chain_in;

   // Each cell hands its item to the next one
   for (genvar i = 0; i < ubdc_pkg::STEPS; i++) begin : g_cell
      ubdc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (links[i]),
         .cell_out (links[i+1])
      );
   end

   assign chain_out = links[ubdc_pkg::STEPS];

endmodule

`default_nettype wire

@@ hw/rtl/ubdc_prescale.sv @@
// Entry stage: peripheral clock from the prescalers, scaled dividend and divisor.
`default_nettype none

module ubdc_prescale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          item_valid,
   input  wire logic [ubdc_pkg::CFG_W-1:0]    clock_config_word,
   input  wire logic                          oversample_by_eight,
   input  wire logic [ubdc_pkg::BAUD_W-1:0]   baud_rate,
   input  wire logic [ubdc_pkg::CLK_W-1:0]    internal_clock_hz,
   input  wire logic [ubdc_pkg::CLK_W-1:0]    external_clock_hz,
   output ubdc_pkg::cell_type                 cell_out
);

   logic [ubdc_pkg::CLK_W-1:0]   sys_clk;
   logic [ubdc_pkg::SHIFT_W-1:0] total_shift;
   logic [ubdc_pkg::CLK_W-1:0]   pclk;
   logic [ubdc_pkg::QUO_W-1:0]   pclk_wide;
   ubdc_pkg::cell_type           cell_in;
   ubdc_pkg::cell_type           cell_ff;

   // Pick the oscillator, divide by both prescalers, form 25*pclk and k*baud
   always_comb begin
      sys_clk     = (clock_config_word[3:2] == 2'b00) ? internal_clock_hz : external_clock_hz;
      total_shift = ubdc_pkg::ahb_shift(clock_config_word[7:4])
                  + ubdc_pkg::apb_shift(clock_config_word[15:13]);
      pclk        = sys_clk >> total_shift;
      pclk_wide   = {{(ubdc_pkg::QUO_W-ubdc_pkg::CLK_W){1'b0}}, pclk};

      cell_in.valid     = item_valid;
      cell_in.over8     = oversample_by_eight;
      cell_in.zero_baud = (baud_rate == '0);
      cell_in.nq        = (pclk_wide << 4) + (pclk_wide << 3) + pclk_wide;
      cell_in.rem       = '0;
      cell_in.den       = oversample_by_eight ? {1'b0, baud_rate, 1'b0}
                                              : {baud_rate, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

@@ hw/rtl/usart_baud_divisor_calc_core.sv @@
// Top level of the USART baud divisor calculator: entry stage, divider row, split, output.
//
// Usage:
//   req_ channel carries one item per handshake: clock configuration word,
//   oversample-by-8 flag and target baud rate. rsp_ channel returns exactly
//   one item per request, in order: the mantissa/fraction divisor word plus
//   mantissa-overflow and zero-baud flags.
//   csr_ port writes the internal (index 0) and external (index 1) oscillator
//   frequencies; write only while no item is in flight.
// Pipeline: the entry register loads at the request handshake edge, then
//   32 cells divide 25*pclk by k*baud, 3 stages split that by 100 with a
//   reciprocal multiply, and 1 output stage rounds the fraction and drives
//   rsp_tvalid.
// Throughput: one item per cycle while the output is not stalled; every stage is a single register.
// Reset: synchronous, clears all valid bits and loads 16 MHz / 8 MHz into
//   the oscillator registers.
// Stall: while rsp_tvalid is high and rsp_tready low the whole pipe holds
//   and req_tready drops; items already inside keep their places.
`default_nettype none

module usart_baud_divisor_calc_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: clock_config_word[15:0], oversample_by_eight[16], baud_rate[40:17]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // response: divisor_word[15:0], mantissa_overflow[16], zero_baud_error[17]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [26:0] csr_wdata
);

   logic [ubdc_pkg::CLK_W-1:0] internal_clock_ff;
   logic [ubdc_pkg::CLK_W-1:0] external_clock_ff;
   logic                       advance;
   ubdc_pkg::cell_type         entry_cell;
   ubdc_pkg::cell_type         div_out;

   // Reciprocal multiply stage
   logic [47:0]                mul_lo_in;
   logic [47:0]                mul_hi_in;
   logic [47:0]                mul_lo_ff;
   logic [47:0]                mul_hi_ff;
   logic                       mul_valid_ff;
   logic                       mul_over8_ff;
   logic                       mul_zero_ff;
   logic [ubdc_pkg::QUO_W-1:0] mul_div_ff;

   // Mantissa stage
   logic [63:0]                  recip_sum;
   logic [ubdc_pkg::QMANT_W-1:0] quo_mant_in;
   logic [ubdc_pkg::QMANT_W-1:0] quo_mant_ff;
   logic                         quo_valid_ff;
   logic                         quo_over8_ff;
   logic                         quo_zero_ff;
   logic [ubdc_pkg::QUO_W-1:0]   quo_div_ff;

   // Hundredths stage
   logic [ubdc_pkg::QUO_W-1:0]   mant_wide;
   logic [ubdc_pkg::QUO_W-1:0]   mant_x100;
   logic [ubdc_pkg::QUO_W-1:0]   rest;
   logic [6:0]                   hnd_hund_in;
   logic [6:0]                   hnd_hund_ff;
   logic [ubdc_pkg::QMANT_W-1:0] hnd_mant_ff;
   logic                         hnd_valid_ff;
   logic                         hnd_over8_ff;
   logic                         hnd_zero_ff;

   logic [10:0]                scaled;
   logic [21:0]                prod;
   logic [4:0]                 frac_raw;
   logic [3:0]                 frac;

   logic                       rsp_valid_ff;
   logic [ubdc_pkg::WORD_W-1:0] divisor_ff;
   logic [ubdc_pkg::WORD_W-1:0] divisor_in;
   logic                       overflow_ff;
   logic                       overflow_in;
   logic                       zero_ff;

   // Oscillator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         internal_clock_ff <= ubdc_pkg::INTERNAL_CLOCK_RESET;
         external_clock_ff <= ubdc_pkg::EXTERNAL_CLOCK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ubdc_pkg::CSR_INTERNAL_CLOCK: internal_clock_ff <= csr_wdata;
            ubdc_pkg::CSR_EXTERNAL_CLOCK: external_clock_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Move the whole pipe whenever the output slot is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   ubdc_prescale u_prescale (
      .clock               (clock),
      .reset               (reset),
      .en                  (advance),
      .item_valid          (req_tvalid),
      .clock_config_word   (req_tdata[15:0]),
      .oversample_by_eight (req_tdata[16]),
      .baud_rate           (req_tdata[40:17]),
      .internal_clock_hz   (internal_clock_ff),
      .external_clock_hz   (external_clock_ff),
      .cell_out            (entry_cell)
   );

   // usartdiv = 25*pclk / (k*baud)
   ubdc_div_chain u_div_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .chain_in  (entry_cell),
      .chain_out (div_out)
   );

   // Multiply usartdiv by the reciprocal of 100 in two halves
   always_comb begin
      mul_lo_in = {16'd0, div_out.nq} * {32'd0, ubdc_pkg::DIV100_MUL_LO};
      mul_hi_in = {16'd0, div_out.nq} * {32'd0, ubdc_pkg::DIV100_MUL_HI};
   end

   // Sum the halves and keep the mantissa
   always_comb begin
      recip_sum   = {mul_hi_ff, 16'd0} + {16'd0, mul_lo_ff};
      quo_mant_in = recip_sum[63:ubdc_pkg::DIV100_SHIFT];
   end

   // Hundredths are what is left after taking 100 times the mantissa
   always_comb begin
      mant_wide   = {{(ubdc_pkg::QUO_W-ubdc_pkg::QMANT_W){1'b0}}, quo_mant_ff};
      mant_x100   = (mant_wide << 6) + (mant_wide << 5) + (mant_wide << 2);
      rest        = quo_div_ff - mant_x100;
      hnd_hund_in = rest[6:0];
   end

   // Advance the split stages
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         quo_valid_ff <= 1'b0;
         hnd_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= div_out.valid;
         mul_over8_ff <= div_out.over8;
         mul_zero_ff  <= div_out.zero_baud;
         mul_div_ff   <= div_out.nq;
         mul_lo_ff    <= mul_lo_in;
         mul_hi_ff    <= mul_hi_in;

         quo_valid_ff <= mul_valid_ff;
         quo_over8_ff <= mul_over8_ff;
         quo_zero_ff  <= mul_zero_ff;
         quo_div_ff   <= mul_div_ff;
         quo_mant_ff  <= quo_mant_in;

         hnd_valid_ff <= quo_valid_ff;
         hnd_over8_ff <= quo_over8_ff;
         hnd_zero_ff  <= quo_zero_ff;
         hnd_mant_ff  <= quo_mant_ff;
         hnd_hund_ff  <= hnd_hund_in;
      end
   end

   // Round the hundredths to eighths or sixteenths; drop the carry
   always_comb begin
      scaled   = hnd_over8_ff ? ({1'b0, hnd_hund_ff, 3'b000} + ubdc_pkg::ROUND_HALF)
                              : ({hnd_hund_ff, 4'b0000} + ubdc_pkg::ROUND_HALF);
      prod     = {11'd0, scaled} * {11'd0, ubdc_pkg::RECIP_100};
      frac_raw = prod[ubdc_pkg::RECIP_SHIFT+4:ubdc_pkg::RECIP_SHIFT];
      frac     = hnd_over8_ff ? {1'b0, frac_raw[2:0]} : frac_raw[3:0];
      divisor_in  = hnd_zero_ff ? '0 : {hnd_mant_ff[ubdc_pkg::MANT_W-1:0], frac};
      overflow_in = !hnd_zero_ff
                    && (|hnd_mant_ff[ubdc_pkg::QMANT_W-1:ubdc_pkg::MANT_W]);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= hnd_valid_ff;
         divisor_ff   <= divisor_in;
         overflow_ff  <= overflow_in;
         zero_ff      <= hnd_zero_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, zero_ff, overflow_ff, divisor_ff};

   // A zero baud rate yields an all-zero word and no overflow
   a_zero_baud_word : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[15:0] == 16'd0 && !rsp_tdata[16])
      else $error("zero baud item carries a nonzero word or overflow");

   // No request is taken while a waiting response is stalled
   a_no_accept_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while output stalled");

   // Nothing comes out in the cycle after reset
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
